[rtl/lpr_pkg.sv]
// Shared types and constants for the line point rasteriser.
// Used by the controller, the datapath and the top level; depends on nothing.
package lpr_pkg;

    // Coordinate width fixed by the stream fields
    localparam int CoordW       = 6;
    localparam int GridSizeDef  = 64;

    // Stream widths: four coordinates in, row and column out (padded to bytes)
    localparam int InDataW  = 4 * CoordW;
    localparam int OutDataW = ((2 * CoordW + 7) / 8) * 8;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // register the clamped endpoints
        logic setup_a;   // form the deltas and their magnitudes
        logic setup_b;   // pick the major axis and order the endpoints
        logic step;      // load the output register and advance one cell
    } lpr_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic zero;      // both endpoints equal
        logic last;      // current cell is the final one of the line
    } lpr_sts_t;

endpackage

[rtl/lpr_ctrl.sv]
// Controller state machine for the line point rasteriser.
// Depends on lpr_pkg; drives the datapath through lpr_cmd_t and owns the output valid.
module lpr_ctrl
    import lpr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output lpr_cmd_t cmd,
    input  lpr_sts_t sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SET_A,
        ST_SET_B,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   load_ok;

    // The output register may take a new cell when empty or being drained
    assign load_ok = !m_tvalid_reg || m_tready;

    // Decode commands and next state
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SET_A;
                end
            end
            ST_SET_A:
            begin
                cmd.setup_a = 1'b1;
                state_next  = ST_SET_B;
            end
            ST_SET_B:
            begin
                cmd.setup_b = 1'b1;
                state_next  = ST_RUN;
            end
            ST_RUN:
            begin
                if (load_ok)
                begin
                    cmd.step      = 1'b1;
                    m_tvalid_next = 1'b1;
                    if (sts.zero || sts.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

[rtl/lpr_dp.sv]
// Datapath for the line point rasteriser: endpoint registers, setup arithmetic,
// the incremental floor-interpolation stepper and the output register. Depends on lpr_pkg.
module lpr_dp
    import lpr_pkg::*;
#(
    parameter int GRID_SIZE = GridSizeDef
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [InDataW-1:0]  s_tdata,
    input  lpr_cmd_t            cmd,
    output lpr_sts_t            sts,
    output logic [OutDataW-1:0] m_tdata,   // [5:0] point_row, [11:6] point_col, rest zero
    output logic                m_tuser,   // [0] point_valid
    output logic                m_tlast
);

    localparam int MaxCoord = GRID_SIZE - 1;
    localparam int AccW     = CoordW + 2;

    typedef logic [CoordW-1:0] coord_t;

    coord_t                   in_r0, in_c0, in_r1, in_c1;
    coord_t                   r0_reg, c0_reg, r1_reg, c1_reg;
    logic signed [CoordW:0]   dr_reg, dc_reg;
    coord_t                   adr_reg, adc_reg;
    logic                     zero_reg;
    logic                     row_major_reg;
    coord_t                   major_reg, minor_reg;
    coord_t                   span_reg, rem_reg;
    logic signed [CoordW:0]   dmin_reg;
    logic signed [AccW-1:0]   acc_reg;
    coord_t                   out_row_reg, out_col_reg;
    logic                     out_valid_reg, out_last_reg;

    logic signed [CoordW:0]   dr_w, dc_w;
    logic                     rm_w, swap_w;
    logic signed [CoordW:0]   dmaj_w, dmn_w;
    logic signed [AccW-1:0]   acc_sum, span_ext;

    // Saturate a coordinate to the grid
    function automatic coord_t clamp(input coord_t v);
        coord_t res;
        res = v;
        if (int'(v) > MaxCoord)
        begin
            res = CoordW'(MaxCoord);
        end
        return res;
    endfunction

    assign in_r0 = clamp(s_tdata[CoordW-1:0]);
    assign in_c0 = clamp(s_tdata[2*CoordW-1:CoordW]);
    assign in_r1 = clamp(s_tdata[3*CoordW-1:2*CoordW]);
    assign in_c1 = clamp(s_tdata[4*CoordW-1:3*CoordW]);

    assign dr_w = $signed({1'b0, r1_reg}) - $signed({1'b0, r0_reg});
    assign dc_w = $signed({1'b0, c1_reg}) - $signed({1'b0, c0_reg});

    // Major axis is the larger span; a tie goes to the column
    assign rm_w   = (adc_reg < adr_reg);
    assign dmaj_w = rm_w ? dr_reg : dc_reg;
    assign dmn_w  = rm_w ? dc_reg : dr_reg;
    assign swap_w = dmaj_w[CoordW];

    assign acc_sum  = acc_reg + AccW'(dmin_reg);
    assign span_ext = $signed({2'b00, span_reg});

    // Capture endpoints and run the setup steps
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            r0_reg <= in_r0;
            c0_reg <= in_c0;
            r1_reg <= in_r1;
            c1_reg <= in_c1;
        end
        if (cmd.setup_a)
        begin
            dr_reg   <= dr_w;
            dc_reg   <= dc_w;
            adr_reg  <= dr_w[CoordW] ? CoordW'(-dr_w) : dr_w[CoordW-1:0];
            adc_reg  <= dc_w[CoordW] ? CoordW'(-dc_w) : dc_w[CoordW-1:0];
            zero_reg <= (r0_reg == r1_reg) && (c0_reg == c1_reg);
        end
        if (cmd.setup_b)
        begin
            row_major_reg <= rm_w;
            if (swap_w)
            begin
                major_reg <= rm_w ? r1_reg : c1_reg;
                minor_reg <= rm_w ? c1_reg : r1_reg;
                dmin_reg  <= -dmn_w;
            end
            else
            begin
                major_reg <= rm_w ? r0_reg : c0_reg;
                minor_reg <= rm_w ? c0_reg : r0_reg;
                dmin_reg  <= dmn_w;
            end
            span_reg <= rm_w ? adr_reg : adc_reg;
            rem_reg  <= rm_w ? adr_reg : adc_reg;
            acc_reg  <= '0;
        end
        // Advance one major step; the accumulator stays in [0, span)
        if (cmd.step)
        begin
            major_reg <= major_reg + 1'b1;
            rem_reg   <= rem_reg - 1'b1;
            if (acc_sum < 0)
            begin
                acc_reg   <= acc_sum + span_ext;
                minor_reg <= minor_reg - 1'b1;
            end
            else if (acc_sum >= span_ext)
            begin
                acc_reg   <= acc_sum - span_ext;
                minor_reg <= minor_reg + 1'b1;
            end
            else
            begin
                acc_reg <= acc_sum;
            end
        end
    end

    // Load the output register with the current cell or the empty marker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.step)
        begin
            if (zero_reg)
            begin
                out_row_reg   <= '0;
                out_col_reg   <= '0;
                out_valid_reg <= 1'b0;
                out_last_reg  <= 1'b1;
            end
            else
            begin
                out_row_reg   <= row_major_reg ? major_reg : minor_reg;
                out_col_reg   <= row_major_reg ? minor_reg : major_reg;
                out_valid_reg <= 1'b1;
                out_last_reg  <= (rem_reg == CoordW'(1));
            end
        end
    end

    assign sts.zero = zero_reg;
    assign sts.last = (rem_reg == CoordW'(1));

    assign m_tdata = OutDataW'({out_col_reg, out_row_reg});
    assign m_tuser = out_valid_reg;
    assign m_tlast = out_last_reg;

endmodule

[rtl/line_point_rasterizer.sv]
// Line point rasteriser: emits the grid cells of the line between two endpoints.
// Usage:
//   Slave channel: one transfer carries both endpoints. tdata holds
//   start_row, start_col, end_row, end_col, six bits each, from bit 0 up.
//   Master channel: one transfer per cell, row in tdata[5:0], column in
//   tdata[11:6]; tuser is point_valid and tlast marks the final cell.
//   The cells run along the major axis (larger span, column on a tie) from
//   the lower major endpoint up to but excluding the other one; the minor
//   coordinate is the exact floor of the interpolation. Equal endpoints give
//   a single transfer with tuser low, tlast high and zero coordinates.
//   Coordinates above GRID_SIZE-1 are saturated on input.
// Timing:
//   After the input transfer the setup states ST_SET_A and ST_SET_B follow,
//   then ST_RUN loads the first cell into the output register. Cells leave
//   at one per cycle, while the receiver accepts them, from a single
//   accumulate-and-correct stepper.
//   The next input is taken once the final cell sits in the output register.
//   When the receiver stalls the output register holds its cell and the
//   stepper waits. Reset empties the output register and returns to idle.
module line_point_rasterizer
    import lpr_pkg::*;
#(
    parameter int GRID_SIZE = GridSizeDef
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // start_row, start_col, end_row, end_col
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,   // point_row, point_col, zero padding
    output logic                m_tuser,   // point_valid
    output logic                m_tlast    // last_point
);

    lpr_cmd_t cmd;
    lpr_sts_t sts;

    lpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    lpr_dp #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

[rtl/lpr_checker.sv]
// Port-level checks for the line point rasteriser.
// Depends on lpr_pkg; bound to line_point_rasterizer at the end of this file.
module lpr_checker
    import lpr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata,
    input logic                m_tuser,
    input logic                m_tlast
);

    // A stalled cell holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("stalled output transfer changed");

    // The empty-line marker is a lone, zeroed, final transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
    else $error("empty-line marker malformed");

    // An accepted line occupies the block for the setup cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
    else $error("input taken during setup");

    // No new line while a non-final cell of the current one is held
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken in the middle of a line");

endmodule

bind line_point_rasterizer lpr_checker u_lpr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
